@@ rtl/ima_pkg.sv @@
`timescale 1ns / 1ps

package ima_pkg;

  // Default sizing of the breakpoint table.
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the two channels.
  localparam int RANGE_KEY_W   = 32;
  localparam int VALUE_W       = 8;
  localparam int ENTRY_INDEX_W = 4;
  localparam int ENTRY_KEY_W   = 32;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [RANGE_KEY_W-1:0] range_start;
    logic [RANGE_KEY_W-1:0] range_end;
    logic [VALUE_W-1:0]     fill_value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [ENTRY_KEY_W-1:0]   entry_key;
    logic [VALUE_W-1:0]       entry_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;
  } out_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_load;
    logic init_wr;
    logic accept;
    logic scan;
    logic commit;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_done;
    logic emit_last;
  } sts_t;

endpackage

@@ rtl/ima_ram.sv @@
`timescale 1ns / 1ps

module ima_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ima_ctrl.sv @@
`timescale 1ns / 1ps

module ima_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output ima_pkg::cmd_t cmd,
  input  ima_pkg::sts_t sts
);

  ima_pkg::state_t state_r;
  ima_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ima_pkg::S_INIT: begin
        state_nxt = ima_pkg::S_IDLE;
      end
      ima_pkg::S_IDLE: begin
        if (cfg_valid) begin
          state_nxt = ima_pkg::S_INIT;
        end else if (start) begin
          state_nxt = sts.empty ? ima_pkg::S_EMIT : ima_pkg::S_SCAN;
        end
      end
      ima_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ima_pkg::S_COMMIT;
        end
      end
      ima_pkg::S_COMMIT: begin
        state_nxt = ima_pkg::S_EMIT;
      end
      ima_pkg::S_EMIT: begin
        if (sts.emit_last) begin
          state_nxt = ima_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ima_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.cfg_load = (state_r == ima_pkg::S_IDLE) && cfg_valid;
    cmd.init_wr  = (state_r == ima_pkg::S_INIT);
    cmd.accept   = (state_r == ima_pkg::S_IDLE) && !cfg_valid && start;
    cmd.scan     = (state_r == ima_pkg::S_SCAN);
    cmd.commit   = (state_r == ima_pkg::S_COMMIT);
    cmd.emit     = (state_r == ima_pkg::S_EMIT);
    busy         = (state_r != ima_pkg::S_IDLE) || cfg_valid;
    cfg_ready    = (state_r == ima_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ima_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A finished scan always hands over to the commit step.
  a_scan_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ima_pkg::S_SCAN) && sts.scan_done |=> (state_r == ima_pkg::S_COMMIT))
    else $error("scan end did not lead to commit");

  // Emission runs without a gap until the final entry.
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ima_pkg::S_EMIT) && !sts.emit_last |=> (state_r == ima_pkg::S_EMIT))
    else $error("table emission stopped early");

endmodule

@@ rtl/ima_dp.sv @@
`timescale 1ns / 1ps

module ima_dp #(
  parameter int CAPACITY  = ima_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ima_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ima_pkg::cmd_t               cmd,
  output ima_pkg::sts_t               sts,
  input  ima_pkg::in_t                in_data,
  input  logic [ima_pkg::VALUE_W-1:0] cfg_data,
  output logic                        out_valid,
  output ima_pkg::out_t               out_data
);

  localparam int VW      = ima_pkg::VALUE_W;
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int OC_W    = $clog2(CAPACITY + 3);
  localparam int RAM_W   = KEY_WIDTH + VW;
  localparam int OKEY_W  = ima_pkg::ENTRY_KEY_W;
  localparam int OIDX_W  = ima_pkg::ENTRY_INDEX_W;
  localparam int OCNT_W  = ima_pkg::ENTRY_COUNT_W;

  // Control state.
  logic                act_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    idx_nxt;
  logic [OC_W-1:0]     oc_r;
  logic                ovf_r;
  logic                done_s_r;
  logic                done_e_r;
  logic                out_valid_r;
  ima_pkg::status_t    status_r;
  logic [VW-1:0]       cfg_r;

  // Payload state.
  logic [KEY_WIDTH-1:0] s_r;
  logic [KEY_WIDTH-1:0] e_r;
  logic [VW-1:0]        v_r;
  logic [VW-1:0]        at_end_r;
  logic [VW-1:0]        last_val_r;
  ima_pkg::out_t        out_r;

  // Table banks.
  logic [RAM_W-1:0] q0;
  logic [RAM_W-1:0] q1;
  logic [RAM_W-1:0] wdata;
  logic [IDX_W-1:0] waddr;
  logic             we0;
  logic             we1;
  logic             scan_wr;

  logic [KEY_WIDTH-1:0] in_s;
  logic [KEY_WIDTH-1:0] in_e;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VW-1:0]        rd_val;
  logic                 exhausted;
  logic                 push;
  logic [KEY_WIDTH-1:0] push_key;
  logic [VW-1:0]        push_val;
  logic                 adv;
  logic                 take_s;
  logic                 take_e;
  logic                 upd_at;
  logic                 scan_done;
  logic                 keep;
  logic                 emit_last;

  assign in_s   = KEY_WIDTH'(in_data.range_start);
  assign in_e   = KEY_WIDTH'(in_data.range_end);
  assign rd_key = act_r ? q1[RAM_W-1:VW] : q0[RAM_W-1:VW];
  assign rd_val = act_r ? q1[VW-1:0] : q0[VW-1:0];

  // One step of the merge walk over the current table. The old entries are
  // visited in key order; the new breakpoints at the range start and at the
  // range end are slotted in where they belong, and old entries covered by
  // the range are dropped.
  always_comb begin
    exhausted = (idx_r == count_r);
    push      = 1'b0;
    push_key  = s_r;
    push_val  = v_r;
    adv       = 1'b0;
    take_s    = 1'b0;
    take_e    = 1'b0;
    upd_at    = 1'b0;
    scan_done = 1'b0;
    if (!exhausted && (rd_key < s_r)) begin
      push     = 1'b1;
      push_key = rd_key;
      push_val = rd_val;
      adv      = 1'b1;
      upd_at   = 1'b1;
    end else if (!done_s_r) begin
      push   = 1'b1;
      take_s = 1'b1;
    end else if (!exhausted && (rd_key <= e_r)) begin
      adv    = 1'b1;
      upd_at = 1'b1;
    end else if (!done_e_r) begin
      push     = 1'b1;
      push_key = e_r;
      push_val = at_end_r;
      take_e   = 1'b1;
    end else if (!exhausted) begin
      push     = 1'b1;
      push_key = rd_key;
      push_val = rd_val;
      adv      = 1'b1;
    end else begin
      scan_done = 1'b1;
    end
  end

  // A pushed breakpoint is kept only if its value differs from the last kept.
  assign keep      = push && ((oc_r == '0) || (push_val != last_val_r));
  assign emit_last = ((idx_r + CNT_W'(1)) == count_r);

  always_comb begin
    idx_nxt = '0;
    if (cmd.emit) begin
      idx_nxt = emit_last ? '0 : idx_r + CNT_W'(1);
    end else if (cmd.scan && !scan_done) begin
      idx_nxt = idx_r + CNT_W'(adv);
    end
  end

  assign scan_wr = cmd.scan && keep && (oc_r < OC_W'(CAPACITY));
  assign waddr   = cmd.init_wr ? '0 : oc_r[IDX_W-1:0];
  assign wdata   = cmd.init_wr ? {{KEY_WIDTH{1'b0}}, cfg_r} : {push_key, push_val};
  assign we0     = (cmd.init_wr && !act_r) || (scan_wr && act_r);
  assign we1     = (cmd.init_wr && act_r) || (scan_wr && !act_r);

  ima_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt[IDX_W-1:0]),
    .rdata (q0)
  );

  ima_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt[IDX_W-1:0]),
    .rdata (q1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      count_r     <= CNT_W'(1);
      idx_r       <= '0;
      oc_r        <= '0;
      ovf_r       <= 1'b0;
      done_s_r    <= 1'b0;
      done_e_r    <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ima_pkg::ST_APPLIED;
      cfg_r       <= '0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.cfg_load) begin
        cfg_r <= cfg_data;
      end
      if (cmd.init_wr) begin
        count_r <= CNT_W'(1);
      end
      if (cmd.accept) begin
        oc_r     <= '0;
        ovf_r    <= 1'b0;
        done_s_r <= 1'b0;
        done_e_r <= 1'b0;
        status_r <= (in_s < in_e) ? ima_pkg::ST_APPLIED : ima_pkg::ST_EMPTY;
      end
      if (cmd.scan) begin
        if (keep) begin
          oc_r <= oc_r + OC_W'(1);
          if (oc_r == OC_W'(CAPACITY)) begin
            ovf_r <= 1'b1;
          end
        end
        if (take_s) begin
          done_s_r <= 1'b1;
        end
        if (take_e) begin
          done_e_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (ovf_r) begin
          status_r <= ima_pkg::ST_FULL;
        end else begin
          act_r   <= !act_r;
          count_r <= oc_r[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r <= in_s;
      e_r <= in_e;
      v_r <= in_data.fill_value;
    end
    if (cmd.scan) begin
      if (upd_at) begin
        at_end_r <= rd_val;
      end
      if (keep) begin
        last_val_r <= push_val;
      end
    end
    out_r.status      <= status_r;
    out_r.entry_index <= OIDX_W'(idx_r);
    out_r.entry_key   <= OKEY_W'(rd_key);
    out_r.entry_value <= rd_val;
    out_r.entry_count <= OCNT_W'(count_r);
    out_r.last        <= emit_last;
  end

  always_comb begin
    sts           = '0;
    sts.empty     = !(in_s < in_e);
    sts.scan_done = scan_done;
    sts.emit_last = emit_last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(CAPACITY)))
    else $error("breakpoint count out of range");

  a_build_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= OC_W'(CAPACITY + 2))
    else $error("rebuilt table grew past its bound");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && ovf_r |=> $stable(count_r) && $stable(act_r))
    else $error("rejected assignment changed the table");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |=> !out_valid_r)
    else $error("beat followed the final entry");

endmodule

@@ rtl/interval_map_range_assign.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                     Payload
// input    start, busy (start & !busy)   in_data  : range_start, range_end, fill_value
// result   out_valid (one-cycle strobe)  out_data : status, entry_index, entry_key,
//                                                   entry_value, entry_count, last
// config   cfg_valid, cfg_ready          cfg_data : base_value
//
// An assignment runs a merge walk over the n current breakpoints, a commit step and
// an emit of the m breakpoints left after it; an empty range skips walk and commit.
// The walk reads old breakpoints through the single read port of the current bank,
// one breakpoint a cycle except on the steps that insert the range start or end.
// Reset, and every base value write, passes through the init state, which writes entry 0.
// Results are strobed out with no back pressure; busy drops in the final beat's cycle.

module interval_map_range_assign #(
  parameter int CAPACITY  = ima_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ima_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ima_pkg::in_t                in_data,
  output logic                        out_valid,
  output ima_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ima_pkg::VALUE_W-1:0] cfg_data
);

  // The controller sequences init, walk, commit and emit; the datapath holds
  // the two table banks (one current, one being rebuilt) and the walk logic.
  ima_pkg::cmd_t cmd;
  ima_pkg::sts_t sts;

  ima_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // On commit the rebuilt bank becomes current, unless the rebuilt table
  // would overflow, in which case the old bank stays and status reads full.
  ima_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
